FILE: rtl/core/sbfc_pkg.sv
`timescale 1ns / 1ps

package sbfc_pkg;

   localparam logic [7:0] START_BYTE  = 8'hFF;
   localparam logic [7:0] CRC_POLY    = 8'h31;
   localparam logic [7:0] CRC_INIT    = 8'hFF;
   localparam int         PAYLOAD_LEN = 4;
   localparam int         PAY_IDX_W   = $clog2(PAYLOAD_LEN);

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_PAY0  = 3'd1,
      PH_PAY1  = 3'd2,
      PH_PAY2  = 3'd3,
      PH_PAY3  = 3'd4,
      PH_CHECK = 3'd5
   } phase_type;

   typedef struct packed {
      logic       frame_ok;
      logic [7:0] blue_distance;
      logic [8:0] blue_angle;
      logic [7:0] yellow_distance;
      logic [8:0] yellow_angle;
   } result_type;

   // CRC-8, MSB first, one byte absorbed
   function automatic logic [7:0] crc8_absorb(logic [7:0] acc, logic [7:0] data);
      logic [7:0] v;
      v = acc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (v[7]) begin
            v = {v[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

FILE: rtl/core/sbfc_frame.sv
`timescale 1ns / 1ps

module sbfc_frame
   import sbfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output logic       emit,
   output result_type result
);

   phase_type        state_ff, state_in;
   logic [7:0]       crc_ff, crc_in;
   logic [7:0]       payload_ff [PAYLOAD_LEN];
   logic             pay_we;
   logic [PAY_IDX_W-1:0] pay_idx;
   logic [7:0]       held_bd_ff, held_bd_in;
   logic [8:0]       held_ba_ff, held_ba_in;
   logic [7:0]       held_yd_ff, held_yd_in;
   logic [8:0]       held_ya_ff, held_ya_in;
   logic             ok;
   logic             hold_we;

   assign emit    = (state_ff == PH_CHECK);
   assign ok      = (rx_byte == crc_ff);
   assign hold_we = step && emit && ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= PH_IDLE;
         crc_ff     <= CRC_INIT;
         held_bd_ff <= '0;
         held_ba_ff <= '0;
         held_yd_ff <= '0;
         held_ya_ff <= '0;
      end else begin
         state_ff   <= state_in;
         crc_ff     <= crc_in;
         held_bd_ff <= held_bd_in;
         held_ba_ff <= held_ba_in;
         held_yd_ff <= held_yd_in;
         held_ya_ff <= held_ya_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pay_we) begin
         payload_ff[pay_idx] <= rx_byte;
      end
   end

   always_comb begin
      state_in = state_ff;
      crc_in   = crc_ff;
      pay_we   = 1'b0;
      pay_idx  = '0;
      if (step) begin
         case (state_ff)
            PH_IDLE: begin
               if (rx_byte == START_BYTE) begin
                  state_in = PH_PAY0;
                  crc_in   = CRC_INIT;
               end
            end
            PH_PAY0: begin
               pay_we   = 1'b1;
               pay_idx  = PAY_IDX_W'(0);
               crc_in   = crc8_absorb(crc_ff, rx_byte);
               state_in = PH_PAY1;
            end
            PH_PAY1: begin
               pay_we   = 1'b1;
               pay_idx  = PAY_IDX_W'(1);
               crc_in   = crc8_absorb(crc_ff, rx_byte);
               state_in = PH_PAY2;
            end
            PH_PAY2: begin
               pay_we   = 1'b1;
               pay_idx  = PAY_IDX_W'(2);
               crc_in   = crc8_absorb(crc_ff, rx_byte);
               state_in = PH_PAY3;
            end
            PH_PAY3: begin
               pay_we   = 1'b1;
               pay_idx  = PAY_IDX_W'(3);
               crc_in   = crc8_absorb(crc_ff, rx_byte);
               state_in = PH_CHECK;
            end
            PH_CHECK: begin
               state_in = PH_IDLE;
               crc_in   = CRC_INIT;
            end
            default: begin
               state_in = PH_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      held_bd_in = held_bd_ff;
      held_ba_in = held_ba_ff;
      held_yd_in = held_yd_ff;
      held_ya_in = held_ya_ff;
      if (hold_we) begin
         held_bd_in = payload_ff[0];
         held_ba_in = {payload_ff[1], 1'b0};
         held_yd_in = payload_ff[2];
         held_ya_in = {payload_ff[3], 1'b0};
      end
      result.frame_ok        = ok;
      result.blue_distance   = held_bd_in;
      result.blue_angle      = held_ba_in;
      result.yellow_distance = held_yd_in;
      result.yellow_angle    = held_ya_in;
   end

   a_check_returns_idle: assert property (@(posedge clock) disable iff (reset)
      step && state_ff == PH_CHECK |=> state_ff == PH_IDLE && crc_ff == CRC_INIT)
      else $error("check byte did not return frame to idle");

   a_held_only_on_match: assert property (@(posedge clock) disable iff (reset)
      !hold_we |=> $stable(held_bd_ff) && $stable(held_ba_ff)
                   && $stable(held_yd_ff) && $stable(held_ya_ff))
      else $error("held values changed without a matching check");

   a_idle_drops_noise: assert property (@(posedge clock) disable iff (reset)
      step && state_ff == PH_IDLE && rx_byte != START_BYTE |=> state_ff == PH_IDLE)
      else $error("non-start byte left idle");

   a_angle_even: assert property (@(posedge clock) disable iff (reset)
      !held_ba_ff[0] && !held_ya_ff[0])
      else $error("held angle is odd");

endmodule

FILE: rtl/core/sbfc_rsp_reg.sv
`timescale 1ns / 1ps

module sbfc_rsp_reg
   import sbfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type data,
   output logic       ready,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output logic       rsp_frame_ok,
   output logic [7:0] rsp_blue_distance,
   output logic [8:0] rsp_blue_angle,
   output logic [7:0] rsp_yellow_distance,
   output logic [8:0] rsp_yellow_angle
);

   logic       vld_ff, vld_in;
   result_type data_ff;

   assign ready  = !vld_ff || !rsp_stall;
   assign vld_in = load || (vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign rsp_valid           = vld_ff;
   assign rsp_frame_ok        = data_ff.frame_ok;
   assign rsp_blue_distance   = data_ff.blue_distance;
   assign rsp_blue_angle      = data_ff.blue_angle;
   assign rsp_yellow_distance = data_ff.yellow_distance;
   assign rsp_yellow_angle    = data_ff.yellow_angle;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      vld_ff && rsp_stall |-> !load)
      else $error("held item overwritten");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      load |=> vld_ff)
      else $error("loaded item not presented");

   a_drain_clears: assert property (@(posedge clock) disable iff (reset)
      vld_ff && !rsp_stall && !load |=> !vld_ff)
      else $error("taken item presented again");

endmodule

FILE: rtl/core/start_byte_frame_crc8_receiver.sv
`timescale 1ns / 1ps

// channel | ports                          | direction
// req     | req_valid, req_stall, req_rx_byte | in (byte from serial link)
// rsp     | rsp_valid, rsp_stall, rsp_frame_ok, rsp_blue_distance,
//         | rsp_blue_angle, rsp_yellow_distance, rsp_yellow_angle | out
//
// One byte per cycle sustained; set by the combinational frame update between
// the input register and the result register. A check byte's item passes the
// input register and then the result register before it is presented. Synchronous
// reset clears the frame state, CRC and held values. A stalled result holds; bytes
// that yield no item keep flowing while it waits, a check byte waits behind it.

module start_byte_frame_crc8_receiver
   import sbfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_frame_ok,
   output logic [7:0] rsp_blue_distance,
   output logic [8:0] rsp_blue_angle,
   output logic [7:0] rsp_yellow_distance,
   output logic [8:0] rsp_yellow_angle
);

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       in_take;
   logic       advance;
   logic       emit;
   logic       rsp_ready;
   result_type result;

   assign advance   = in_vld_ff && (!emit || rsp_ready);
   assign req_stall = in_vld_ff && !advance;
   assign in_take   = req_valid && !req_stall;
   assign in_vld_in = in_take || (in_vld_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   sbfc_frame u_frame (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .emit    (emit),
      .result  (result)
   );

   sbfc_rsp_reg u_rsp (
      .clock               (clock),
      .reset               (reset),
      .load                (advance && emit),
      .data                (result),
      .ready               (rsp_ready),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_frame_ok        (rsp_frame_ok),
      .rsp_blue_distance   (rsp_blue_distance),
      .rsp_blue_angle      (rsp_blue_angle),
      .rsp_yellow_distance (rsp_yellow_distance),
      .rsp_yellow_angle    (rsp_yellow_angle)
   );

   a_take_needs_room: assert property (@(posedge clock) disable iff (reset)
      in_take |-> !in_vld_ff || advance)
      else $error("input register overrun");

   a_stall_holds_byte: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !advance |=> in_vld_ff && $stable(in_byte_ff))
      else $error("waiting byte lost");

   a_item_from_check: assert property (@(posedge clock) disable iff (reset)
      advance && !emit |=> $stable(rsp_valid) || $fell(rsp_valid))
      else $error("item produced by a non-check byte");

endmodule

FILE: sim/start_byte_frame_crc8_receiver_tb.sv
`timescale 1ns / 1ps

module start_byte_frame_crc8_receiver_tb;
   import sbfc_pkg::*;

   localparam int ITEM_TARGET  = 1200;
   localparam int HOLD_CYCLES  = 100;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 16;

   class frame_scoreboard;
      phase_type  ph;
      logic [7:0] crc;
      logic [7:0] pay [PAYLOAD_LEN];
      result_type held;
      result_type pending [$];
      int         errors;

      function new();
         ph     = PH_IDLE;
         crc    = CRC_INIT;
         held   = '0;
         errors = 0;
      endfunction

      // bitwise MSB-first CRC-8
      static function logic [7:0] crc_step(logic [7:0] acc, logic [7:0] d);
         logic [7:0] r;
         r = acc;
         for (int i = 7; i >= 0; i--) begin
            r = {r[6:0], 1'b0} ^ ((r[7] ^ d[i]) ? CRC_POLY : 8'h00);
         end
         return r;
      endfunction

      task report(string msg);
         $display("%0t ns mismatch: %s", $realtime, msg);
         errors++;
      endtask

      function void note_byte(logic [7:0] rx);
         result_type r;
         case (ph)
            PH_PAY0, PH_PAY1, PH_PAY2, PH_PAY3: begin
               pay[ph - PH_PAY0] = rx;
               crc = crc_step(crc, rx);
               ph  = phase_type'(ph + 3'd1);
            end
            PH_CHECK: begin
               r          = held;
               r.frame_ok = (rx == crc);
               if (r.frame_ok) begin
                  r.blue_distance   = pay[0];
                  r.blue_angle      = {pay[1], 1'b0};
                  r.yellow_distance = pay[2];
                  r.yellow_angle    = {pay[3], 1'b0};
               end
               held = r;
               pending.push_back(r);
               ph  = PH_IDLE;
               crc = CRC_INIT;
            end
            default: begin
               ph = PH_IDLE;
               if (rx == START_BYTE) begin
                  crc = CRC_INIT;
                  ph  = PH_PAY0;
               end
            end
         endcase
      endfunction

      task check_result(result_type got);
         result_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result item, frame_ok=%0b", got.frame_ok));
            return;
         end
         want = pending.pop_front();
         if (got.frame_ok !== want.frame_ok)
            report($sformatf("frame_ok %0b, want %0b", got.frame_ok, want.frame_ok));
         if (got.blue_distance !== want.blue_distance)
            report($sformatf("blue_distance %0d, want %0d",
                             got.blue_distance, want.blue_distance));
         if (got.blue_angle !== want.blue_angle)
            report($sformatf("blue_angle %0d, want %0d", got.blue_angle, want.blue_angle));
         if (got.yellow_distance !== want.yellow_distance)
            report($sformatf("yellow_distance %0d, want %0d",
                             got.yellow_distance, want.yellow_distance));
         if (got.yellow_angle !== want.yellow_angle)
            report($sformatf("yellow_angle %0d, want %0d",
                             got.yellow_angle, want.yellow_angle));
      endtask
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_frame_ok;
   logic [7:0] rsp_blue_distance;
   logic [8:0] rsp_blue_angle;
   logic [7:0] rsp_yellow_distance;
   logic [8:0] rsp_yellow_angle;

   frame_scoreboard sb = new();
   bit quiet;
   bit hold_request;
   int sent_count;
   int idle_cycles;

   start_byte_frame_crc8_receiver dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_frame_ok        (rsp_frame_ok),
      .rsp_blue_distance   (rsp_blue_distance),
      .rsp_blue_angle      (rsp_blue_angle),
      .rsp_yellow_distance (rsp_yellow_distance),
      .rsp_yellow_angle    (rsp_yellow_angle)
   );

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      rsp_stall   = 1'b0;
   end

   always #2 clock = ~clock;

   // accepted items, watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall)
            sb.check_result({rsp_frame_ok, rsp_blue_distance, rsp_blue_angle,
                             rsp_yellow_distance, rsp_yellow_angle});
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // result side back-pressure
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 9);
      end
   end

   task automatic send_byte(input logic [7:0] rx);
      while (!quiet && $urandom_range(0, 99) < 9) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [7:0] p0, p1, p2, p3, input logic [7:0] flip);
      logic [7:0] c;
      c = frame_scoreboard::crc_step(CRC_INIT, p0);
      c = frame_scoreboard::crc_step(c, p1);
      c = frame_scoreboard::crc_step(c, p2);
      c = frame_scoreboard::crc_step(c, p3);
      send_byte(START_BYTE);
      send_byte(p0);
      send_byte(p1);
      send_byte(p2);
      send_byte(p3);
      send_byte(c ^ flip);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      logic [7:0] flip;
      int         sel;
      bit         hold_done;
      hold_done = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // dropped while idle
      send_byte(8'h00);
      send_byte(8'hFE);
      send_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      // start byte inside the frame, largest angles
      send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00);
      // failed check keeps the held values
      send_frame(8'h01, 8'h02, 8'h03, 8'h04, 8'h01);
      send_frame(8'hAA, 8'h55, 8'h80, 8'h7F, 8'h00);

      while (sent_count < ITEM_TARGET) begin
         quiet = (sent_count >= 400 && sent_count < 600);
         if (!hold_done && sent_count >= 800) begin
            hold_request = 1'b1;
            hold_done    = 1'b1;
         end
         sel = $urandom_range(0, 9);
         if (sel < 7) begin
            flip = ($urandom_range(0, 4) == 0) ? 8'(1 << $urandom_range(0, 7)) : 8'h00;
            send_frame(pick_byte(), pick_byte(), pick_byte(), pick_byte(), flip);
         end else if (sel < 9) begin
            repeat ($urandom_range(1, 4))
               send_byte(($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom_range(0, 254)));
         end else begin
            // truncated frame, the next bytes complete it
            send_byte(START_BYTE);
            repeat ($urandom_range(0, 3)) send_byte(pick_byte());
         end
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
